@@ rtl/fpsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsc_pkg
// Widths and polynomial constants for the fixed-point sine and cosine block.
// ----------------------------------------------------------------------------
package fpsc_pkg;

    localparam int ANGLE_W = 14;
    localparam int RES_W   = 14;
    localparam int SQ_W    = 25;
    localparam int SQ_SH   = 24;
    localparam int OUT_SH  = 31;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 14'd4096;
    localparam logic [ANGLE_W-1:0] HALF_TURN    = 14'd8192;

    localparam logic [31:0] C1 = 32'd3373259426;
    localparam logic [30:0] C2 = 31'd1377809732;
    localparam logic [27:0] C3 = 28'd152033954;

    localparam int P1_W = 28 + SQ_W;
    localparam int P2_W = 31 + SQ_W;
    localparam int P3_W = 33 + ANGLE_W;

    typedef logic signed [ANGLE_W-1:0] t_z;
    typedef logic [SQ_W-1:0]           t_sq;

endpackage

@@ rtl/fpsc_fold.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsc_fold
// Applies the cosine offset when i_mode is high and folds the angle into the
// first or fourth quadrant, registering the signed reduced angle.
// ----------------------------------------------------------------------------
module fpsc_fold
    import fpsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [ANGLE_W-1:0] i_angle,
    input  logic               i_mode,
    output logic               o_vld,
    output t_z                 o_z
);

    logic [ANGLE_W-1:0] n_a;
    t_z                 n_z;
    logic               r_vld;
    t_z                 r_z;

    always_comb begin
        n_a = i_mode ? ANGLE_W'(QUARTER_TURN - i_angle) : i_angle;
        if (n_a[ANGLE_W-1] ^ n_a[ANGLE_W-2]) begin
            n_z = t_z'(HALF_TURN - n_a);
        end else begin
            n_z = t_z'(n_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z <= n_z;
    end

    assign o_vld = r_vld;
    assign o_z   = r_z;

endmodule

@@ rtl/fpsc_poly.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsc_poly
// Four-stage multiplier pipeline that evaluates z*(C1 - z^2*(C2 - z^2*C3))
// and leaves the full-precision product in its last stage.
// ----------------------------------------------------------------------------
module fpsc_poly
    import fpsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  t_z                     i_z,
    output logic                   o_vld,
    output logic signed [P3_W-1:0] o_prod
);

    logic [3:0]              r_vld;
    t_z                      r2_z;
    t_sq                     r2_sq;
    t_z                      r3_z;
    t_sq                     r3_sq;
    logic [P1_W-1:0]         r3_p1;
    t_z                      r4_z;
    logic [P2_W-1:0]         r4_p2;
    logic signed [P3_W-1:0]  r5_p3;

    logic [SQ_W:0]           n_sq;
    logic [P1_W-1:0]         n_p1;
    logic [30:0]             n_y2;
    logic [P2_W-1:0]         n_p2;
    logic [31:0]             n_y4;
    logic signed [P3_W-1:0]  n_p3;

    always_comb begin
        n_sq = (SQ_W+1)'($signed(i_z) * $signed(i_z));
        n_p1 = P1_W'(C3 * r2_sq);
        n_y2 = C2 - 31'(r3_p1[P1_W-2:SQ_SH]);
        n_p2 = P2_W'(n_y2 * r3_sq);
        n_y4 = C1 - 32'(r4_p2[P2_W-2:SQ_SH]);
        n_p3 = P3_W'($signed({1'b0, n_y4}) * r4_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r2_z  <= i_z;
        r2_sq <= n_sq[SQ_W-1:0];
        r3_z  <= r2_z;
        r3_sq <= r2_sq;
        r3_p1 <= n_p1;
        r4_z  <= r3_z;
        r4_p2 <= n_p2;
        r5_p3 <= n_p3;
    end

    assign o_vld  = r_vld[3];
    assign o_prod = r5_p3;

endmodule

@@ rtl/fixed_point_sine_cosine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_sine_cosine_top
// Sine or cosine of a Q12 quarter-turn angle by a fifth-order polynomial.
//
// A word is taken at each rising edge where start is high and busy is low;
// i_angle carries the angle (16384 is a full turn) and i_mode selects sine
// (0) or cosine (1). busy is high only during reset and the cycle after it,
// so one word can be accepted in every cycle.
// Each result appears on o_result, a signed Q12 value from -4096 to 4096,
// for exactly one cycle while o_strobe is high. The receiver cannot hold
// results off, and none is needed since nothing waits inside the block.
// From the accepting edge to the edge that takes the result, a word passes
// through one fold stage, squaring, three polynomial multiply stages that
// each end in a register, and the output register. Throughput is one word
// per cycle. Results leave in the order their words entered.
// Reset clears all valid bits, so no result is presented after reset until
// a new word is accepted.
// ----------------------------------------------------------------------------
module fixed_point_sine_cosine_top
    import fpsc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [ANGLE_W-1:0]       i_angle,
    input  logic                     i_mode,
    output logic                     o_strobe,
    output logic signed [RES_W-1:0]  o_result
);

    logic                    w_fold_vld;
    t_z                      w_z;
    logic                    w_poly_vld;
    logic signed [P3_W-1:0]  w_prod;
    logic                    r_busy;
    logic                    r_strobe;
    logic signed [RES_W-1:0] r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    fpsc_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !r_busy),
        .i_angle (i_angle),
        .i_mode  (i_mode),
        .o_vld   (w_fold_vld),
        .o_z     (w_z)
    );

    fpsc_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_fold_vld),
        .i_z     (w_z),
        .o_vld   (w_poly_vld),
        .o_prod  (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_poly_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= w_prod[OUT_SH+RES_W-1:OUT_SH];
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_strobe_from_accept: assert property (@(posedge i_clk)
        o_strobe |-> $past(start && !busy, 6))
        else $error("result strobe without a matching accepted word");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result >= -14'sd4096 && o_result <= 14'sd4096))
        else $error("result outside the unit range");

    a_busy_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> !busy)
        else $error("busy high outside reset");

endmodule
